// ----- src/mrbls_pkg.sv -----
// Package for the marker ring border line scanner.
// Holds the configuration register set, register indexes, area and outcome codes.
// No dependencies.
package mrbls_pkg;

  // Default coordinate width of pixel_x / pixel_y and of the border fields.
  localparam int unsigned CoordWidthDef = 12;

  // Width of a color code and of the configuration data.
  localparam int unsigned CodeWidth = 8;

  // Width of the scan direction tag.
  localparam int unsigned DirWidth = 3;

  // Width of the result outcome field.
  localparam int unsigned OutcomeWidth = 2;

  // Width of the unrecognized pixel counter.
  localparam int unsigned UnkCntWidth = 9;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxWidth = 3;

  // Code that the initial area takes as its own.
  localparam logic [CodeWidth-1:0] InitialMark = 8'd254;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_CODE_BLUE    = 3'd0,
    REG_CODE_RED     = 3'd1,
    REG_CODE_GREEN   = 3'd2,
    REG_CODE_UNKNOWN = 3'd3,
    REG_CODE_BLACK   = 3'd4,
    REG_CODE_WHITE   = 3'd5,
    REG_MAX_UNKNOWN  = 3'd6
  } cfg_reg_e;

  // Result outcome codes.
  typedef enum logic [OutcomeWidth-1:0] {
    OUT_VALID  = 2'd0,
    OUT_REJECT = 2'd1,
    OUT_NO_END = 2'd2
  } outcome_e;

  // Area of the scan line, one-hot.
  typedef enum logic [4:0] {
    AREA_INITIAL = 5'b00001,
    AREA_BLUE    = 5'b00010,
    AREA_RED     = 5'b00100,
    AREA_GREEN   = 5'b01000,
    AREA_AFTER   = 5'b10000
  } area_e;

  // Configuration register set.
  typedef struct packed {
    logic [CodeWidth-1:0] code_blue;
    logic [CodeWidth-1:0] code_red;
    logic [CodeWidth-1:0] code_green;
    logic [CodeWidth-1:0] code_unknown;
    logic [CodeWidth-1:0] code_black;
    logic [CodeWidth-1:0] code_white;
    logic [CodeWidth-1:0] max_unknown;
  } cfg_t;

  // Configuration values after reset.
  localparam cfg_t CfgReset = '{
    code_blue:    8'd1,
    code_red:     8'd2,
    code_green:   8'd3,
    code_unknown: 8'd0,
    code_black:   8'd4,
    code_white:   8'd5,
    max_unknown:  8'd10
  };

endpackage

// ----- src/marker_ring_border_line_scanner.sv -----
// Top level of the marker ring border line scanner: configuration registers,
// input register stage and scan core. Depends on mrbls_pkg, mrbls_in_reg, mrbls_core.
//
// Channel  | Direction | Item
// s_axis   | in        | one pixel of a scan line, tlast marks the line's final pixel
// m_axis   | out       | one result per scan line (valid, rejected or red end not found)
// cfg      | in        | one register write, index and 8-bit value
//
// One pixel item is taken per cycle while m_axis does not stall. The pixel goes
// into the input register at the edge that accepts it and is folded into the line
// state when the scan core takes it, which also loads the result register that
// drives m_axis. All state updates for a pixel are done together in the scan core.
// A stall on m_axis holds the result and backs up into the input register, then
// into s_axis_tready. Reset clears all line state and loads the default color
// codes; cfg writes are always taken.
module marker_ring_border_line_scanner
  import mrbls_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // pixel_code, pixel_x, pixel_y, line_direction, zero fill
  input  logic [((CodeWidth + 2*COORD_WIDTH + DirWidth + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // last_of_line
  input  logic                   s_axis_tlast,
  // outcome, inner_x, inner_y, outer_x, outer_y, result_direction, zero fill
  output logic [((OutcomeWidth + 4*COORD_WIDTH + DirWidth + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CodeWidth-1:0]   cfg_data_i
);

  localparam int unsigned IN_W = ((CodeWidth + 2*COORD_WIDTH + DirWidth + 7) / 8) * 8;

  cfg_t cfg_q;

  logic            item_valid;
  logic            item_take;
  logic [IN_W-1:0] item_data;
  logic            item_last;

  // Configuration registers; a write is always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CODE_BLUE:    cfg_q.code_blue    <= cfg_data_i;
        REG_CODE_RED:     cfg_q.code_red     <= cfg_data_i;
        REG_CODE_GREEN:   cfg_q.code_green   <= cfg_data_i;
        REG_CODE_UNKNOWN: cfg_q.code_unknown <= cfg_data_i;
        REG_CODE_BLACK:   cfg_q.code_black   <= cfg_data_i;
        REG_CODE_WHITE:   cfg_q.code_white   <= cfg_data_i;
        REG_MAX_UNKNOWN:  cfg_q.max_unknown  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register stage.
  mrbls_in_reg #(
    .DATA_W (IN_W)
  ) u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .valid_o   (item_valid),
    .take_i    (item_take),
    .data_o    (item_data),
    .last_o    (item_last)
  );

  // Scan core with result register.
  mrbls_core #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (item_valid),
    .in_take_o   (item_take),
    .in_data_i   (item_data),
    .in_last_i   (item_last),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- src/mrbls_in_reg.sv -----
// Input register stage of the marker ring border line scanner.
// Holds one accepted pixel item until the scan core takes it.
// Depends on nothing outside this file.
module mrbls_in_reg #(
  parameter int unsigned DATA_W = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [DATA_W-1:0] s_data_i,
  input  logic              s_last_i,
  output logic              valid_o,
  input  logic              take_i,
  output logic [DATA_W-1:0] data_o,
  output logic              last_o
);

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] data_q;
  logic              last_q;

  // The stage is free when empty or when its item leaves in this cycle.
  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      data_q <= s_data_i;
      last_q <= s_last_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

// ----- src/mrbls_core.sv -----
// Scan core of the marker ring border line scanner: line state, area rules and
// the result register. Depends on mrbls_pkg.
module mrbls_core
  import mrbls_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_take_o,
  input  logic [((CodeWidth + 2*COORD_WIDTH + DirWidth + 7) / 8) * 8 - 1:0] in_data_i,
  input  logic                 in_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [((OutcomeWidth + 4*COORD_WIDTH + DirWidth + 7) / 8) * 8 - 1:0] out_data_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned OUT_W = ((OutcomeWidth + 4*CW + DirWidth + 7) / 8) * 8;
  localparam int unsigned OUT_USED = OutcomeWidth + 4*CW + DirWidth;

  // Unpacked fields of the pixel item.
  logic [CodeWidth-1:0] pix_code;
  logic [CW-1:0]        pix_x, pix_y;
  logic [DirWidth-1:0]  pix_dir;

  assign pix_code = in_data_i[CodeWidth-1:0];
  assign pix_x    = in_data_i[CodeWidth +: CW];
  assign pix_y    = in_data_i[CodeWidth+CW +: CW];
  assign pix_dir  = in_data_i[CodeWidth+2*CW +: DirWidth];

  // Line state.
  area_e                  area_q, area_d;
  logic [CodeWidth-1:0]   prev_code_q, prev_code_d;
  logic                   prev_present_q, prev_present_d;
  logic [CW-1:0]          run_x_q, run_x_d, run_y_q, run_y_d;
  logic [UnkCntWidth-1:0] unk_cnt_q, unk_cnt_d;
  logic [CW-1:0]          inner_x_q, inner_x_d, inner_y_q, inner_y_d;
  logic [CW-1:0]          outer_x_q, outer_x_d, outer_y_q, outer_y_d;
  logic                   settled_q, settled_d;

  // Result register.
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  // Per-item decision signals.
  logic                   fire;
  logic                   is_unknown;
  logic [UnkCntWidth-1:0] unk_cnt_inc;
  logic                   over_limit;
  logic                   new_run;
  logic [CodeWidth-1:0]   area_code;
  area_e                  adv_area;
  logic                   adv_rej;
  logic                   adv_inner, adv_outer;
  logic                   emit, clear_line;
  outcome_e               res_outcome;
  logic [CW-1:0]          res_inner_x, res_inner_y, res_outer_x, res_outer_y;

  // An item moves on when the result register is free or being emptied.
  assign fire      = in_valid_i && (!out_valid_q || out_ready_i);
  assign in_take_o = fire;

  // Unrecognized pixel count and limit check.
  assign is_unknown  = (pix_code == cfg_i.code_unknown);
  assign unk_cnt_inc = is_unknown ? unk_cnt_q + 1'b1 : unk_cnt_q;
  assign over_limit  = is_unknown && (unk_cnt_inc > {1'b0, cfg_i.max_unknown});
  assign new_run     = !prev_present_q || (pix_code != prev_code_q);

  // Code that belongs to the current area.
  always_comb begin
    case (area_q)
      AREA_BLUE:  area_code = cfg_i.code_blue;
      AREA_RED:   area_code = cfg_i.code_red;
      AREA_GREEN: area_code = cfg_i.code_green;
      AREA_AFTER: area_code = cfg_i.code_unknown;
      default:    area_code = InitialMark;
    endcase
  end

  // Area rules for a confirmed run of a code other than the area's own.
  always_comb begin
    adv_area  = area_q;
    adv_rej   = 1'b0;
    adv_inner = 1'b0;
    adv_outer = 1'b0;
    if (pix_code != area_code) begin
      case (area_q)
        AREA_INITIAL: begin
          if (pix_code != cfg_i.code_blue) begin
            adv_rej = 1'b1;
          end else begin
            adv_area = AREA_BLUE;
          end
        end
        AREA_BLUE: begin
          if (pix_code == cfg_i.code_red) begin
            adv_area  = AREA_RED;
            adv_inner = 1'b1;
          end else if (pix_code == cfg_i.code_green) begin
            adv_rej = 1'b1;
          end
        end
        AREA_RED: begin
          if (pix_code == cfg_i.code_green) begin
            adv_area  = AREA_GREEN;
            adv_outer = 1'b1;
          end else if (pix_code == cfg_i.code_blue) begin
            adv_rej = 1'b1;
          end else if (is_unknown || pix_code == cfg_i.code_black ||
                       pix_code == cfg_i.code_white) begin
            adv_area  = AREA_AFTER;
            adv_outer = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next line state and result for the item that moves on.
  always_comb begin
    area_d         = area_q;
    prev_code_d    = prev_code_q;
    prev_present_d = prev_present_q;
    run_x_d        = run_x_q;
    run_y_d        = run_y_q;
    unk_cnt_d      = unk_cnt_q;
    inner_x_d      = inner_x_q;
    inner_y_d      = inner_y_q;
    outer_x_d      = outer_x_q;
    outer_y_d      = outer_y_q;
    settled_d      = settled_q;
    emit           = 1'b0;
    clear_line     = 1'b0;
    res_outcome    = OUT_VALID;

    if (fire) begin
      if (settled_q) begin
        // A settled line only waits for its last pixel.
        clear_line = in_last_i;
      end else begin
        unk_cnt_d = unk_cnt_inc;
        if (over_limit) begin
          emit        = 1'b1;
          res_outcome = (area_q inside {AREA_GREEN, AREA_AFTER}) ? OUT_VALID : OUT_NO_END;
          clear_line  = in_last_i;
          settled_d   = !in_last_i;
        end else if (new_run) begin
          prev_code_d    = pix_code;
          prev_present_d = 1'b1;
          run_x_d        = pix_x;
          run_y_d        = pix_y;
          if (in_last_i) begin
            emit        = 1'b1;
            res_outcome = (area_q inside {AREA_GREEN, AREA_AFTER}) ? OUT_VALID : OUT_NO_END;
            clear_line  = 1'b1;
          end
        end else if (adv_rej) begin
          emit        = 1'b1;
          res_outcome = OUT_REJECT;
          clear_line  = in_last_i;
          settled_d   = !in_last_i;
        end else begin
          area_d = adv_area;
          if (adv_inner) begin
            inner_x_d = run_x_q;
            inner_y_d = run_y_q;
          end
          if (adv_outer) begin
            outer_x_d = run_x_q;
            outer_y_d = run_y_q;
          end
          if (in_last_i) begin
            emit        = 1'b1;
            res_outcome = (adv_area inside {AREA_GREEN, AREA_AFTER}) ? OUT_VALID : OUT_NO_END;
            clear_line  = 1'b1;
          end
        end
      end
    end

    // The result shows the borders as they stand after this pixel.
    res_inner_x = inner_x_d;
    res_inner_y = inner_y_d;
    res_outer_x = outer_x_d;
    res_outer_y = outer_y_d;

    // A closed line starts over from the reset values.
    if (clear_line) begin
      area_d         = AREA_INITIAL;
      prev_code_d    = '0;
      prev_present_d = 1'b0;
      run_x_d        = '0;
      run_y_d        = '0;
      unk_cnt_d      = '0;
      inner_x_d      = '0;
      inner_y_d      = '0;
      outer_x_d      = '0;
      outer_y_d      = '0;
      settled_d      = 1'b0;
    end
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q         <= AREA_INITIAL;
      prev_code_q    <= '0;
      prev_present_q <= 1'b0;
      run_x_q        <= '0;
      run_y_q        <= '0;
      unk_cnt_q      <= '0;
      inner_x_q      <= '0;
      inner_y_q      <= '0;
      outer_x_q      <= '0;
      outer_y_q      <= '0;
      settled_q      <= 1'b0;
    end else begin
      area_q         <= area_d;
      prev_code_q    <= prev_code_d;
      prev_present_q <= prev_present_d;
      run_x_q        <= run_x_d;
      run_y_q        <= run_y_d;
      unk_cnt_q      <= unk_cnt_d;
      inner_x_q      <= inner_x_d;
      inner_y_q      <= inner_y_d;
      outer_x_q      <= outer_x_d;
      outer_y_q      <= outer_y_d;
      settled_q      <= settled_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, packed from the lowest bit up.
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_data_q <= {{(OUT_W - OUT_USED){1'b0}}, pix_dir, res_outer_y, res_outer_x,
                     res_inner_y, res_inner_x, res_outcome};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/mrbls_checker.sv -----
// Port-level checker for the marker ring border line scanner, bound to the top level.
// Depends on mrbls_pkg and marker_ring_border_line_scanner.
module mrbls_checker
  import mrbls_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic [((CodeWidth + 2*COORD_WIDTH + DirWidth + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic [((OutcomeWidth + 4*COORD_WIDTH + DirWidth + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o
);

  // A stalled result holds its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The outcome is one of the three defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == OUT_VALID || m_axis_tdata[1:0] == OUT_REJECT ||
                       m_axis_tdata[1:0] == OUT_NO_END))
    else $error("undefined outcome code");

  // Input backpressure only comes from a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled result");

  // A refused pixel item stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("pixel item changed while refused");

  // Configuration writes are never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind marker_ring_border_line_scanner mrbls_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_mrbls_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the marker ring border line scanner.
// Streams scan lines of color-coded pixels, predicts one verdict per line and
// checks every result field. Depends on mrbls_pkg and marker_ring_border_line_scanner.
module tb;
  import mrbls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = CoordWidthDef;
  localparam int unsigned InUsed = CodeWidth + 2 * CW + DirWidth;
  localparam int unsigned InW = ((InUsed + 7) / 8) * 8;
  localparam int unsigned OutW = ((OutcomeWidth + 4 * CW + DirWidth + 7) / 8) * 8;
  localparam int unsigned PipeLatency = 2;
  localparam int unsigned MaxPrinted = 50;

  // Which color a generated run of pixels takes its code from.
  typedef enum int unsigned {
    SEL_BLUE,
    SEL_RED,
    SEL_GREEN,
    SEL_UNKNOWN,
    SEL_BLACK,
    SEL_WHITE,
    SEL_MARK,
    SEL_NOISE
  } color_sel_e;

  // One expected line verdict.
  typedef struct packed {
    outcome_e          outcome;
    logic [CW-1:0]     inner_x;
    logic [CW-1:0]     inner_y;
    logic [CW-1:0]     outer_x;
    logic [CW-1:0]     outer_y;
    logic [DirWidth-1:0] dir;
  } line_verdict_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic [InW-1:0]         s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic                   s_axis_tlast;
  logic [OutW-1:0]        m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CodeWidth-1:0]   cfg_data_i;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned pixels_sent;
  int unsigned mismatch_count;

  // Scanner model state.
  cfg_t            cfg_model;
  area_e           area_q;
  logic [7:0]      prev_code_q;
  logic            prev_valid_q;
  logic [CW-1:0]   run_x_q;
  logic [CW-1:0]   run_y_q;
  logic [UnkCntWidth-1:0] unk_cnt_q;
  logic [CW-1:0]   inner_x_q;
  logic [CW-1:0]   inner_y_q;
  logic [CW-1:0]   outer_x_q;
  logic [CW-1:0]   outer_y_q;
  logic            settled_q;
  line_verdict_t   pending_verdicts[$];

  marker_ring_border_line_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Run limit, far above the slowest correct run.
  initial begin
    #8ms;
    $display("marker_ring_border_line_scanner regression: fail");
    $finish;
  end

  // Result sink stalls at random according to the current idle share.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // Compare every accepted result with the oldest pending verdict.
  always @(posedge clk_i) begin : result_check
    line_verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_error("result with no verdict pending");
      end else begin
        want = pending_verdicts.pop_front();
        check_field("outcome", m_axis_tdata[OutcomeWidth-1:0], want.outcome);
        check_field("inner_x", m_axis_tdata[OutcomeWidth+:CW], want.inner_x);
        check_field("inner_y", m_axis_tdata[OutcomeWidth+CW+:CW], want.inner_y);
        check_field("outer_x", m_axis_tdata[OutcomeWidth+2*CW+:CW], want.outer_x);
        check_field("outer_y", m_axis_tdata[OutcomeWidth+3*CW+:CW], want.outer_y);
        check_field("direction", m_axis_tdata[OutcomeWidth+4*CW+:DirWidth], want.dir);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  task automatic clear_line_model();
    area_q       = AREA_INITIAL;
    prev_code_q  = '0;
    prev_valid_q = 1'b0;
    run_x_q      = '0;
    run_y_q      = '0;
    unk_cnt_q    = '0;
    inner_x_q    = '0;
    inner_y_q    = '0;
    outer_x_q    = '0;
    outer_y_q    = '0;
    settled_q    = 1'b0;
  endtask

  function automatic logic [7:0] area_own_code();
    case (area_q)
      AREA_BLUE:  return cfg_model.code_blue;
      AREA_RED:   return cfg_model.code_red;
      AREA_GREEN: return cfg_model.code_green;
      AREA_AFTER: return cfg_model.code_unknown;
      default:    return InitialMark;
    endcase
  endfunction

  task automatic push_verdict(input outcome_e outcome, input logic [DirWidth-1:0] dir);
    line_verdict_t v;
    v.outcome = outcome;
    v.inner_x = inner_x_q;
    v.inner_y = inner_y_q;
    v.outer_x = outer_x_q;
    v.outer_y = outer_y_q;
    v.dir     = dir;
    pending_verdicts.push_back(v);
  endtask

  // The end of red counts as found once green or the after-red area is reached.
  function automatic outcome_e closing_outcome();
    return (area_q inside {AREA_GREEN, AREA_AFTER}) ? OUT_VALID : OUT_NO_END;
  endfunction

  // Move through the ring areas on a confirmed run; flags a bad color order.
  task automatic advance_area(input logic [7:0] code, output logic reject);
    reject = 1'b0;
    if (code != area_own_code()) begin
      case (area_q)
        AREA_INITIAL: begin
          if (code != cfg_model.code_blue) reject = 1'b1;
          else area_q = AREA_BLUE;
        end
        AREA_BLUE: begin
          if (code == cfg_model.code_red) begin
            inner_x_q = run_x_q;
            inner_y_q = run_y_q;
            area_q    = AREA_RED;
          end else if (code == cfg_model.code_green) begin
            reject = 1'b1;
          end
        end
        AREA_RED: begin
          if (code == cfg_model.code_green) begin
            outer_x_q = run_x_q;
            outer_y_q = run_y_q;
            area_q    = AREA_GREEN;
          end else if (code == cfg_model.code_blue) begin
            reject = 1'b1;
          end else if (code == cfg_model.code_unknown || code == cfg_model.code_black ||
                       code == cfg_model.code_white) begin
            outer_x_q = run_x_q;
            outer_y_q = run_y_q;
            area_q    = AREA_AFTER;
          end
        end
        default: ;
      endcase
    end
  endtask

  // Fold one accepted pixel into the model; pushes a verdict when the line gives one.
  task automatic track_pixel(input logic [7:0] code, input logic [CW-1:0] x,
                             input logic [CW-1:0] y, input logic [DirWidth-1:0] dir,
                             input logic last);
    logic reject;
    // After an early verdict the rest of the line is skipped.
    if (settled_q) begin
      if (last) clear_line_model();
      return;
    end
    // Unrecognized pixels are counted first and may end the line at once.
    if (code == cfg_model.code_unknown) begin
      unk_cnt_q = unk_cnt_q + 1'b1;
      if (unk_cnt_q > cfg_model.max_unknown) begin
        push_verdict(closing_outcome(), dir);
        if (last) clear_line_model();
        else settled_q = 1'b1;
        return;
      end
    end
    if (!prev_valid_q || code != prev_code_q) begin
      prev_code_q  = code;
      prev_valid_q = 1'b1;
      run_x_q      = x;
      run_y_q      = y;
    end else begin
      advance_area(code, reject);
      if (reject) begin
        push_verdict(OUT_REJECT, dir);
        if (last) clear_line_model();
        else settled_q = 1'b1;
        return;
      end
    end
    if (last) begin
      push_verdict(closing_outcome(), dir);
      clear_line_model();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic send_pixel(input logic [7:0] code, input logic [CW-1:0] x,
                            input logic [CW-1:0] y, input logic [DirWidth-1:0] dir,
                            input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InW - InUsed){1'b0}}, dir, y, x, code};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
    track_pixel(code, x, y, dir, last);
  endtask

  // Walk a line from a start point with a fixed step; the final pixel closes it.
  task automatic send_line(input logic [7:0] codes[$], input logic [CW-1:0] x0,
                           input logic [CW-1:0] y0, input logic [CW-1:0] dx,
                           input logic [CW-1:0] dy, input logic [DirWidth-1:0] dir);
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    x = x0;
    y = y0;
    foreach (codes[i]) begin
      send_pixel(codes[i], x, y, dir, i == codes.size() - 1);
      x = x + dx;
      y = y + dy;
    end
  endtask

  task automatic send_line_random_walk(input logic [7:0] codes[$]);
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    dx = CW'($urandom_range(2) - 1);
    dy = CW'($urandom_range(2) - 1);
    send_line(codes, CW'($urandom_range(4095)), CW'($urandom_range(4095)), dx, dy,
              DirWidth'($urandom_range(7)));
  endtask

  function automatic logic [7:0] color_code(input color_sel_e sel);
    case (sel)
      SEL_BLUE:    return cfg_model.code_blue;
      SEL_RED:     return cfg_model.code_red;
      SEL_GREEN:   return cfg_model.code_green;
      SEL_UNKNOWN: return cfg_model.code_unknown;
      SEL_BLACK:   return cfg_model.code_black;
      SEL_WHITE:   return cfg_model.code_white;
      SEL_MARK:    return InitialMark;
      default:     return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_run(ref logic [7:0] codes[$], input color_sel_e sel,
                         input int unsigned len);
    logic [7:0] code;
    code = color_code(sel);
    repeat (len) codes.push_back(code);
  endtask

  // Mostly well-ordered rings with random run lengths, some broken orders and noise.
  task automatic send_random_line();
    logic [7:0] codes[$];
    int unsigned shape;
    shape = $urandom_range(9);
    if (shape < 6) begin
      if ($urandom_range(3) == 0) add_run(codes, SEL_MARK, $urandom_range(1, 3));
      add_run(codes, SEL_BLUE, $urandom_range(1, 4));
      if ($urandom_range(5) == 0) add_run(codes, SEL_NOISE, 1);
      add_run(codes, SEL_RED, $urandom_range(1, 4));
      if ($urandom_range(5) == 0) add_run(codes, SEL_UNKNOWN, 1);
      add_run(codes, color_sel_e'($urandom_range(SEL_GREEN, SEL_WHITE)),
              $urandom_range(1, 4));
      repeat ($urandom_range(2)) begin
        add_run(codes, color_sel_e'($urandom_range(SEL_BLUE, SEL_NOISE)),
                $urandom_range(1, 3));
      end
    end else if (shape < 8) begin
      repeat ($urandom_range(2, 4)) begin
        add_run(codes, color_sel_e'($urandom_range(SEL_BLUE, SEL_WHITE)),
                $urandom_range(1, 3));
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        add_run(codes, color_sel_e'($urandom_range(SEL_BLUE, SEL_NOISE)),
                $urandom_range(1, 2));
      end
    end
    send_line_random_walk(codes);
  endtask

  task automatic send_random_lines(input int unsigned count, input bit drain_often);
    int unsigned start;
    int unsigned lines;
    start = pixels_sent;
    lines = 0;
    while (pixels_sent - start < count) begin
      send_random_line();
      lines++;
      if (drain_often && lines % 8 == 0) wait_verdicts_drained();
    end
  endtask

  // Hold the pixel stream until every pending verdict has come out.
  task automatic wait_verdicts_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // Quiet point: no verdict pending and the pipeline given time to empty.
  task automatic wait_block_idle();
    wait_verdicts_drained();
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_reg_e idx;
    logic [7:0] val;
    for (int i = REG_CODE_BLUE; i <= REG_MAX_UNKNOWN; i++) begin
      idx = cfg_reg_e'(i);
      case (idx)
        REG_CODE_BLUE:    val = c.code_blue;
        REG_CODE_RED:     val = c.code_red;
        REG_CODE_GREEN:   val = c.code_green;
        REG_CODE_UNKNOWN: val = c.code_unknown;
        REG_CODE_BLACK:   val = c.code_black;
        REG_CODE_WHITE:   val = c.code_white;
        default:          val = c.max_unknown;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cfg_model = c;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-built lines: each outcome, the initial mark, early end and settled lines.
  task automatic test_directed_cases();
    cfg_t c;
    c = CfgReset;
    c.max_unknown = 8'd1;
    load_config(c);
    // Full ring ending in green, coordinates wrapping at both ends.
    send_line('{8'd1, 8'd1, 8'd2, 8'd2, 8'd3, 8'd3}, 12'd4095, 12'd0, 12'd1, 12'hFFF, 3'd0);
    // Green right after blue rejects; the rest of the line is skipped.
    send_line('{8'd1, 8'd1, 8'd3, 8'd3, 8'd2, 8'd2}, 12'd100, 12'd4095, 12'd0, 12'd1, 3'd7);
    // Second unrecognized pixel passes the limit of one.
    send_line('{8'd0, 8'd0, 8'd5}, 12'd0, 12'd0, 12'd1, 12'd0, 3'd3);
    // Initial mark ahead of blue, red never ends.
    send_line('{InitialMark, InitialMark, 8'd1, 8'd1, 8'd2, 8'd2}, 12'd2730, 12'd1365,
              12'hFFF, 12'd1, 3'd5);
    // Single-pixel line with the largest code.
    send_line('{8'd255}, 12'd4095, 12'd4095, 12'd0, 12'd0, 3'd4);
    // Wrong first color, rejected on the closing pixel.
    send_line('{8'd2, 8'd2}, 12'd2048, 12'd2047, 12'd1, 12'd1, 3'd2);
  endtask

  task automatic test_default_codes();
    wait_block_idle();
    load_config(CfgReset);
    send_random_lines(350, 1'b0);
  endtask

  task automatic test_extreme_codes();
    cfg_t c;
    wait_block_idle();
    c.code_blue    = 8'd0;
    c.code_red     = 8'd255;
    c.code_green   = 8'd254;
    c.code_unknown = 8'd128;
    c.code_black   = 8'd1;
    c.code_white   = 8'd127;
    c.max_unknown  = 8'd0;
    load_config(c);
    send_random_lines(200, 1'b0);
  endtask

  // Highest unrecognized limit: only very long lines reach it.
  task automatic test_unknown_ceiling();
    cfg_t c;
    logic [7:0] codes[$];
    wait_block_idle();
    c.code_blue    = 8'd255;
    c.code_red     = 8'd0;
    c.code_green   = 8'd7;
    c.code_unknown = InitialMark;
    c.code_black   = 8'd253;
    c.code_white   = 8'd2;
    c.max_unknown  = 8'd255;
    load_config(c);
    repeat (2) begin
      codes.delete();
      add_run(codes, SEL_BLUE, 2);
      add_run(codes, SEL_RED, 2);
      add_run(codes, SEL_UNKNOWN, $urandom_range(250, 262));
      add_run(codes, SEL_NOISE, 3);
      send_line_random_walk(codes);
    end
    send_random_lines(100, 1'b0);
  endtask

  // Registers sharing codes, with the stream held after every eighth line until the block drains.
  task automatic test_shared_codes();
    cfg_t c;
    wait_block_idle();
    c.code_blue    = 8'd6;
    c.code_red     = 8'd7;
    c.code_green   = 8'd8;
    c.code_unknown = 8'd8;
    c.code_black   = 8'd8;
    c.code_white   = 8'd6;
    c.max_unknown  = 8'd3;
    load_config(c);
    send_random_lines(300, 1'b1);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_CODE_BLUE;
    cfg_data_i    <= '0;
    src_idle_pct   = 35;
    snk_idle_pct   = 71;
    pixels_sent    = 0;
    mismatch_count = 0;
    cfg_model      = CfgReset;
    clear_line_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_default_codes();
    src_idle_pct = 71;
    snk_idle_pct = 35;
    test_extreme_codes();
    test_unknown_ceiling();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_shared_codes();

    wait_block_idle();
    if (pending_verdicts.size() != 0) begin
      report_error($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    end
    if (mismatch_count == 0) begin
      $display("marker_ring_border_line_scanner regression: pass");
    end else begin
      $display("marker_ring_border_line_scanner regression: fail");
    end
    $finish;
  end

endmodule
